// File: src/efsd_pkg.sv
// Shared types and constants for the earliest-free-server dispatcher.
package efsd_pkg;

    localparam int IDX_W    = 4;
    localparam int TIME_W   = 8;
    localparam int BUSY_W   = 32;
    localparam int COUNT_W  = 8;
    localparam int ACTIVE_W = 5;
    localparam int PADDR_W  = 3;
    localparam int MAX_CELLS = 16;

    // Input actions carried in s_tuser
    localparam logic ACT_LOAD     = 1'b0;
    localparam logic ACT_DISPATCH = 1'b1;

    // Register byte addresses
    localparam logic [PADDR_W-1:0] ADDR_ACTIVE = 3'd0;

    // Search token that walks the cell row
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [BUSY_W-1:0] busy;
        logic [TIME_W-1:0] ptime;
    } scan_t;

    // Broadcast write to the cell row
    typedef struct packed {
        logic              en;
        logic              load;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] ptime;
        logic [BUSY_W-1:0] busy;
    } wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_ADD
    } state_t;

endpackage

// File: src/efsd_cell.sv
// One server cell: holds per-item and busy-until times, updates the passing search token.
module efsd_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [efsd_pkg::ACTIVE_W-1:0]   active_count,
    input  efsd_pkg::wr_t                   wr,
    input  efsd_pkg::scan_t                 scan_in,
    output efsd_pkg::scan_t                 scan_out
);

    localparam logic [efsd_pkg::IDX_W-1:0]    MY_IDX  = efsd_pkg::IDX_W'(CELL_IDX);
    localparam logic [efsd_pkg::ACTIVE_W-1:0] MY_RANK = efsd_pkg::ACTIVE_W'(CELL_IDX);

    logic [efsd_pkg::TIME_W-1:0] time_reg, time_next;
    logic [efsd_pkg::BUSY_W-1:0] busy_reg, busy_next;
    efsd_pkg::scan_t             scan_reg, scan_next;
    logic                        take;

    // Table writes addressed to this server
    always_comb begin
        time_next = time_reg;
        busy_next = busy_reg;
        if (wr.en && (wr.idx == MY_IDX)) begin
            if (wr.load) begin
                time_next = wr.ptime;
                busy_next = '0;
            end else begin
                busy_next = wr.busy;
            end
        end
    end

    // Strict less-than keeps ties on the lower index
    assign take = (MY_RANK < active_count) &&
                  (!scan_in.found || (busy_reg < scan_in.busy));

    always_comb begin
        scan_next = scan_in;
        if (scan_in.valid && take) begin
            scan_next.found = 1'b1;
            scan_next.idx   = MY_IDX;
            scan_next.busy  = busy_reg;
            scan_next.ptime = time_reg;
        end
    end

    // Tables and token; the tables and the token valid bit are reset, the token payload is not
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg       <= efsd_pkg::TIME_W'(1);
            busy_reg       <= '0;
            scan_reg.valid <= 1'b0;
        end else begin
            time_reg       <= time_next;
            busy_reg       <= busy_next;
            scan_reg.valid <= scan_next.valid;
        end
        scan_reg.found <= scan_next.found;
        scan_reg.idx   <= scan_next.idx;
        scan_reg.busy  <= scan_next.busy;
        scan_reg.ptime <= scan_next.ptime;
    end

    assign scan_out = scan_reg;

endmodule

// File: src/efsd_chain.sv
// Row of server cells; the search token moves one cell per cycle.
module efsd_chain #(
    parameter int NUM_CELLS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [efsd_pkg::ACTIVE_W-1:0]   active_count,
    input  efsd_pkg::wr_t                   wr,
    input  efsd_pkg::scan_t                 scan_in,
    output efsd_pkg::scan_t                 scan_out
);

    efsd_pkg::scan_t link [NUM_CELLS+1];

    assign link[0] = scan_in;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        efsd_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .active_count (active_count),
            .wr           (wr),
            .scan_in      (link[i]),
            .scan_out     (link[i+1])
        );
    end

    assign scan_out = link[NUM_CELLS];

endmodule

// File: src/earliest_free_server_dispatch.sv
// Top level of the earliest-free-server dispatcher: control, output register, APB register.
//
// Input stream (s_*): one request per item. s_tuser selects load (0) or dispatch (1);
// s_tlast marks the final job of a batch. A load sets one server's per-item time and
// clears its busy time; it produces no result and completes in the accept cycle.
// A dispatch sends a search token down a row of min(NUM_SERVERS,16) server cells, one
// cell per cycle, then multiplies per-item time by item count and adds, saturating at
// 2^32-1. A dispatch result is registered after the token walks the cell row and the
// multiply (ST_MUL) and add (ST_ADD) states; the next request is accepted in the cycle
// after the write-back, so a new dispatch is not taken before the last one is through.
// Output stream (m_*): one result per dispatch, held in an output register until
// taken; m_tlast echoes the final-job mark. While a result waits, a new request is
// still accepted; a dispatch then holds before its write-back until the output frees.
// APB port: register 0 (byte address 0) is active_servers, reset 16; zero acts as one,
// values above the cell count act as the cell count. Write only while idle.
// Reset (aresetn, synchronous, active low): per-item times become one, busy times and
// the makespan zero, no result pending.
module earliest_free_server_dispatch #(
    parameter int NUM_SERVERS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // APB configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [efsd_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [3:0] server_index, [11:4] per_item_time, [19:12] item_count, [23:20] zero
    input  logic [23:0]                     s_tdata,
    // [0] action
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [3:0] assigned_server, [35:4] finish_time, [67:36] makespan, [71:68] zero
    output logic [71:0]                     m_tdata,
    output logic                            m_tlast
);

    localparam int NUM_CELLS = (NUM_SERVERS < efsd_pkg::MAX_CELLS) ?
                               NUM_SERVERS : efsd_pkg::MAX_CELLS;
    localparam logic [efsd_pkg::ACTIVE_W-1:0] LIMIT = efsd_pkg::ACTIVE_W'(NUM_CELLS);

    efsd_pkg::state_t state_reg, state_next;

    logic [efsd_pkg::ACTIVE_W-1:0] active_reg;
    logic [efsd_pkg::ACTIVE_W-1:0] usable;

    logic [efsd_pkg::COUNT_W-1:0]  count_reg;
    logic                          last_reg;
    logic [efsd_pkg::IDX_W-1:0]    best_idx_reg;
    logic [efsd_pkg::BUSY_W-1:0]   best_busy_reg;
    logic [efsd_pkg::TIME_W-1:0]   best_time_reg;
    logic [efsd_pkg::TIME_W+efsd_pkg::COUNT_W-1:0] prod_reg;
    logic [efsd_pkg::BUSY_W-1:0]   span_reg;

    logic                          m_valid_reg;
    logic [efsd_pkg::IDX_W-1:0]    m_server_reg;
    logic [efsd_pkg::BUSY_W-1:0]   m_finish_reg;
    logic [efsd_pkg::BUSY_W-1:0]   m_span_reg;
    logic                          m_last_reg;

    logic                          s_accept;
    logic                          cfg_write;
    logic                          out_free;
    logic                          commit;
    logic [efsd_pkg::BUSY_W:0]     sum;
    logic [efsd_pkg::BUSY_W-1:0]   finish;
    logic [efsd_pkg::BUSY_W-1:0]   span_new;

    efsd_pkg::wr_t                 wr;
    efsd_pkg::scan_t               scan_in;
    efsd_pkg::scan_t               scan_out;

    // Request fields
    logic [efsd_pkg::IDX_W-1:0]    in_server;
    logic [efsd_pkg::TIME_W-1:0]   in_time;
    logic [efsd_pkg::COUNT_W-1:0]  in_count;

    assign in_server = s_tdata[3:0];
    assign in_time   = s_tdata[11:4];
    assign in_count  = s_tdata[19:12];

    // APB register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == efsd_pkg::ADDR_ACTIVE);
    assign prdata    = (paddr == efsd_pkg::ADDR_ACTIVE) ? {27'd0, active_reg} : 32'd0;

    // Active count clamped to the cell row
    always_comb begin
        usable = active_reg;
        if (usable == '0) begin
            usable = efsd_pkg::ACTIVE_W'(1);
        end
        if (usable > LIMIT) begin
            usable = LIMIT;
        end
    end

    // Write-back arithmetic: saturating busy plus product
    assign sum      = {1'b0, best_busy_reg} + (efsd_pkg::BUSY_W+1)'(prod_reg);
    assign finish   = sum[efsd_pkg::BUSY_W] ? {efsd_pkg::BUSY_W{1'b1}}
                                            : sum[efsd_pkg::BUSY_W-1:0];
    assign span_new = (finish > span_reg) ? finish : span_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Control: next state, handshake, cell-row write and token injection
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        commit     = 1'b0;
        wr         = '0;
        scan_in    = '0;
        case (state_reg)
            efsd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == efsd_pkg::ACT_DISPATCH) begin
                        scan_in.valid = 1'b1;
                        state_next    = efsd_pkg::ST_SCAN;
                    end else begin
                        wr.en    = 1'b1;
                        wr.load  = 1'b1;
                        wr.idx   = in_server;
                        wr.ptime = in_time;
                    end
                end
            end
            efsd_pkg::ST_SCAN: begin
                if (scan_out.valid) begin
                    state_next = efsd_pkg::ST_MUL;
                end
            end
            efsd_pkg::ST_MUL: begin
                state_next = efsd_pkg::ST_ADD;
            end
            efsd_pkg::ST_ADD: begin
                if (out_free) begin
                    commit     = 1'b1;
                    wr.en      = 1'b1;
                    wr.idx     = best_idx_reg;
                    wr.busy    = finish;
                    state_next = efsd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = efsd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= efsd_pkg::ST_IDLE;
            active_reg  <= efsd_pkg::ACTIVE_W'(16);
            span_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_write) begin
                active_reg <= pwdata[efsd_pkg::ACTIVE_W-1:0];
            end
            if (commit) begin
                span_reg    <= span_new;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Job and result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            count_reg <= in_count;
            last_reg  <= s_tlast;
        end
        if ((state_reg == efsd_pkg::ST_SCAN) && scan_out.valid) begin
            best_idx_reg  <= scan_out.idx;
            best_busy_reg <= scan_out.busy;
            best_time_reg <= scan_out.ptime;
        end
        if (state_reg == efsd_pkg::ST_MUL) begin
            prod_reg <= best_time_reg * count_reg;
        end
        if (commit) begin
            m_server_reg <= best_idx_reg;
            m_finish_reg <= finish;
            m_span_reg   <= span_new;
            m_last_reg   <= last_reg;
        end
    end

    efsd_chain #(
        .NUM_CELLS (NUM_CELLS)
    ) u_chain (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .active_count (usable),
        .wr           (wr),
        .scan_in      (scan_in),
        .scan_out     (scan_out)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_span_reg, m_finish_reg, m_server_reg};
    assign m_tlast  = m_last_reg;

endmodule
